// ===== hw/rtl/efb_pkg.sv =====
// Shared types and constants for the escaped frame builder.
// Used by every module in hw/rtl; no dependencies.
`default_nettype none

package efb_pkg;

    localparam int BYTE_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int MAX_OUT  = 5;   // header, length, escape, payload, end code
    localparam int CNT_W    = 3;   // holds 0..MAX_OUT
    localparam int CFG_IDX_W = 2;

    // Register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ENABLE = 2'd2;

    localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd125;
    localparam logic              ESCAPE_EN_RST   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
        logic              escape_enable;
    } efb_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                first_byte;
        logic                last_byte;
        logic [NIBBLE_W-1:0] message_id;
        logic [NIBBLE_W-1:0] data_kind;
        logic [BYTE_W-1:0]   frame_length;
    } efb_item_t;

    // Expanded byte run for one item, slot 0 goes out first
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               cnt;
        logic                           closes;  // last slot is the closing end code
    } efb_job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/escaped_frame_builder.sv =====
// Top level of the escaped frame builder: input register, expansion, result register.
// Depends on efb_pkg, efb_cfg, efb_expand, efb_emit.
`default_nettype none

// Byte-stuffing framer. Each input transfer carries one payload byte and turns
// into a run of 1 to 5 output bytes: header (message_id high nibble, data_kind
// low nibble) and length when first_byte is set, an escape code before a
// payload byte equal to the end or escape code (when escaping is enabled), the
// payload byte, and the end code when last_byte is set. m_tlast marks the last
// byte of each run and m_tuser flags the closing end code. The output sends one
// byte per cycle while m_tready is high, so an item takes one output transfer per
// output byte (1 to 5); the input register refills while the result register
// still drains, so with m_tready held high items flow back to back, one per
// output run. Configuration is written through the cfg_* channel (index 0 end
// code, 1 escape code, 2 escape enable) and must only change while idle.
module escaped_frame_builder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // config write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [efb_pkg::BYTE_W-1:0]    cfg_data,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,  // [7:0] payload_byte, [11:8] message_id,
                                                         // [19:12] frame_length, [23:20] zero
    input  wire logic                          s_tlast,  // last_byte
    input  wire logic [4:0]                    s_tuser,  // [0] first_byte, [4:1] data_kind
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [efb_pkg::BYTE_W-1:0]         m_tdata,  // [7:0] out_byte
    output logic                               m_tlast,  // run_last
    output logic                               m_tuser   // [0] frame_done
);

    efb_pkg::efb_cfg_t  cfg;
    efb_pkg::efb_item_t item_reg;
    efb_pkg::efb_item_t item_next;
    efb_pkg::efb_job_t  job;
    logic               item_valid_reg;
    logic               job_load;

    efb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register is free when empty or when its item moves on this cycle
    assign s_tready = !item_valid_reg || job_load;

    always_comb begin
        item_next.payload_byte = s_tdata[7:0];
        item_next.message_id   = s_tdata[11:8];
        item_next.frame_length = s_tdata[19:12];
        item_next.first_byte   = s_tuser[0];
        item_next.data_kind    = s_tuser[4:1];
        item_next.last_byte    = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

    efb_expand u_expand (
        .item (item_reg),
        .cfg  (cfg),
        .job  (job)
    );

    efb_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (item_valid_reg),
        .job       (job),
        .job_load  (job_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/efb_cfg.sv =====
// Configuration register file: end code, escape code, escape enable.
// Depends on efb_pkg.
`default_nettype none

module efb_cfg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [efb_pkg::BYTE_W-1:0]    cfg_data,
    output efb_pkg::efb_cfg_t                 cfg
);

    efb_pkg::efb_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.end_code      <= efb_pkg::END_CODE_RST;
            cfg_reg.escape_code   <= efb_pkg::ESCAPE_CODE_RST;
            cfg_reg.escape_enable <= efb_pkg::ESCAPE_EN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                efb_pkg::CFG_END_CODE:      cfg_reg.end_code      <= cfg_data;
                efb_pkg::CFG_ESCAPE_CODE:   cfg_reg.escape_code   <= cfg_data;
                efb_pkg::CFG_ESCAPE_ENABLE: cfg_reg.escape_enable <= cfg_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/efb_expand.sv =====
// Expands one registered item into its run of output bytes.
// Depends on efb_pkg.
`default_nettype none

module efb_expand (
    input  efb_pkg::efb_item_t item,
    input  efb_pkg::efb_cfg_t  cfg,
    output efb_pkg::efb_job_t  job
);

    logic                      need_esc;
    logic [efb_pkg::CNT_W-1:0] pos;

    assign need_esc = cfg.escape_enable &&
                      (item.payload_byte == cfg.end_code ||
                       item.payload_byte == cfg.escape_code);

    always_comb begin
        job = '0;
        pos = '0;
        if (item.first_byte) begin
            job.bytes[0] = {item.message_id, item.data_kind};
            job.bytes[1] = item.frame_length;
            pos = efb_pkg::CNT_W'(2);
        end
        if (need_esc) begin
            job.bytes[pos] = cfg.escape_code;
            pos = pos + 1'b1;
        end
        job.bytes[pos] = item.payload_byte;
        pos = pos + 1'b1;
        if (item.last_byte) begin
            job.bytes[pos] = cfg.end_code;
            pos = pos + 1'b1;
        end
        job.cnt    = pos;
        job.closes = item.last_byte;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/efb_emit.sv =====
// Result register: holds one expanded byte run and sends it a byte per transfer.
// Depends on efb_pkg.
`default_nettype none

module efb_emit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        job_valid,
    input  efb_pkg::efb_job_t                job,
    output logic                             job_load,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [efb_pkg::BYTE_W-1:0]       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,   // run_last
    output logic                             m_tuser    // [0] frame_done
);

    logic                      busy_reg;
    efb_pkg::efb_job_t         job_reg;
    logic [efb_pkg::CNT_W-1:0] idx_reg;
    logic                      at_end;

    assign at_end   = (idx_reg == job_reg.cnt - 1'b1);
    assign job_load = !busy_reg || (m_tready && at_end);

    assign m_tvalid = busy_reg;
    assign m_tdata  = job_reg.bytes[idx_reg];
    assign m_tlast  = at_end;
    assign m_tuser  = at_end && job_reg.closes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (job_load) begin
            busy_reg <= job_valid;
            idx_reg  <= '0;
        end else if (m_tready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load && job_valid) begin
            job_reg <= job;
        end
    end

    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < job_reg.cnt) else $error("byte index past run");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (job_reg.cnt != '0 && job_reg.cnt <= efb_pkg::CNT_W'(efb_pkg::MAX_OUT)))
        else $error("run length out of range");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !m_tready) |=> (busy_reg && $stable(idx_reg)))
        else $error("run advanced while stalled");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_tuser) |-> m_tlast) else $error("frame end not last of run");

endmodule

`default_nettype wire
